@@ design/lfu_pkg.sv @@
package lfu_pkg;

    // Operation codes.
    localparam logic [2:0] OP_LOOKUP   = 3'd0;
    localparam logic [2:0] OP_INSERT   = 3'd1;
    localparam logic [2:0] OP_REMOVE   = 3'd2;
    localparam logic [2:0] OP_PRESENCE = 3'd3;
    localparam logic [2:0] OP_EXPIRE   = 3'd4;

    // Status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    // Configuration register indexes.
    localparam logic REG_BUDGET = 1'b0;
    localparam logic REG_LIMIT  = 1'b1;

    localparam logic [39:0] BUDGET_RST = 40'd104857600;
    localparam logic [10:0] LIMIT_RST  = 11'd1000;

    localparam int DEPTH_DEF    = 1024;
    localparam int TAG_BITS_DEF = 64;

    // Entry word layout, from the bottom up; the tag sits on top.
    localparam int F_LOC = 0;
    localparam int F_USE = 1;
    localparam int F_TIM = 33;
    localparam int F_SIZ = 65;
    localparam int F_HND = 105;
    localparam int F_TAG = 137;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] key_tag;
        logic [31:0] handle;
        logic [39:0] item_size;
        logic        local_flag;
        logic [31:0] now;
        logic [31:0] max_age;
        logic        quick;
        logic [1:0]  quick_status;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_handle;
        logic [10:0] removed_count;
        logic [10:0] stored_entries;
        logic [39:0] used_bytes;
    } t_res;

endpackage

@@ design/lfu_ram.sv @@
module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/lfu_front.sv @@
module lfu_front
    import lfu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_req,
    output logic o_full,
    output logic o_valid,
    output t_req o_req,
    input  logic i_pop
);

    t_req       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_req       w_cls;
    logic       w_push;
    logic       w_pop;

    // Requests that need no table access are marked here with their status.
    always_comb begin
        w_cls = i_req;
        w_cls.quick = 1'b0;
        w_cls.quick_status = ST_OK;
        if (i_req.op > OP_EXPIRE) begin
            w_cls.quick = 1'b1;
            w_cls.quick_status = ST_MISS;
        end else if (i_req.op == OP_INSERT && i_req.item_size == '0) begin
            w_cls.quick = 1'b1;
            w_cls.quick_status = ST_ZERO;
        end
    end

    assign o_full  = r_cnt[1];
    assign o_valid = r_cnt != 2'd0;
    assign o_req   = r_q[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cls;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

@@ design/lfu_back.sv @@
module lfu_back
    import lfu_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEF,
    parameter int TAG_BITS    = TAG_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  t_req        i_req,
    output logic        o_req_pop,
    input  logic [39:0] i_budget,
    input  logic [10:0] i_limit,
    output logic        o_res_valid,
    output t_res        o_res,
    input  logic        i_res_ready
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int LW = (CW > 11) ? CW : 11;
    localparam int EW = F_TAG + TAG_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_INS  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam logic [1:0] M_FIND  = 2'd0;
    localparam logic [1:0] M_MIN   = 2'd1;
    localparam logic [1:0] M_SHIFT = 2'd2;
    localparam logic [1:0] M_EXP   = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [1:0]    r_mode, n_mode;
    t_req          r_req, n_req;
    logic [CW-1:0] r_total, n_total;
    logic [39:0]   r_bytes, n_bytes;
    logic [CW-1:0] r_rd, n_rd;
    logic          r_pv, n_pv;
    logic [IW-1:0] r_pidx, n_pidx;
    logic [CW-1:0] r_w, n_w;
    logic [CW-1:0] r_removed, n_removed;
    logic [31:0]   r_bu, n_bu;
    logic [31:0]   r_bt, n_bt;
    logic [IW-1:0] r_bi, n_bi;
    logic [39:0]   r_bs, n_bs;
    logic [1:0]    r_status, n_status;
    logic [31:0]   r_found, n_found;

    logic          w_re;
    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [EW-1:0] w_wdata;
    logic [EW-1:0] w_rdata;

    logic [TAG_BITS-1:0] d_tag;
    logic [31:0]         d_hnd;
    logic [39:0]         d_siz;
    logic [31:0]         d_tim;
    logic [31:0]         d_use;
    logic                d_loc;
    logic [31:0]         w_use_inc;
    logic [LW-1:0]       w_limit;
    logic                w_over;
    logic                w_full;
    logic                w_hit;
    logic                w_less;
    logic                w_expired;
    logic                w_end;

    assign d_tag = w_rdata[F_TAG +: TAG_BITS];
    assign d_hnd = w_rdata[F_HND +: 32];
    assign d_siz = w_rdata[F_SIZ +: 40];
    assign d_tim = w_rdata[F_TIM +: 32];
    assign d_use = w_rdata[F_USE +: 32];
    assign d_loc = w_rdata[F_LOC];

    assign w_use_inc = (d_use == 32'hFFFF_FFFF) ? d_use : d_use + 32'd1;
    assign w_limit   = (LW'(i_limit) > LW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : LW'(i_limit);
    assign w_over    = ({1'b0, r_bytes} + {1'b0, r_req.item_size}) > {1'b0, i_budget};
    assign w_full    = LW'(r_total) >= w_limit;
    assign w_hit     = d_tag == r_req.key_tag[TAG_BITS-1:0];
    assign w_less    = (d_use < r_bu) || (d_use == r_bu && d_tim < r_bt);
    assign w_expired = (r_req.now >= d_tim) && ((r_req.now - d_tim) > r_req.max_age);
    assign w_end     = !r_pv && (r_rd >= r_total);

    assign o_res_valid          = r_state == S_DONE;
    assign o_res.status         = r_status;
    assign o_res.found_handle   = r_found;
    assign o_res.removed_count  = 11'(r_removed);
    assign o_res.stored_entries = 11'(r_total);
    assign o_res.used_bytes     = r_bytes;

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_req     = r_req;
        n_total   = r_total;
        n_bytes   = r_bytes;
        n_rd      = r_rd;
        n_pv      = 1'b0;
        n_pidx    = r_pidx;
        n_w       = r_w;
        n_removed = r_removed;
        n_bu      = r_bu;
        n_bt      = r_bt;
        n_bi      = r_bi;
        n_bs      = r_bs;
        n_status  = r_status;
        n_found   = r_found;
        o_req_pop = 1'b0;
        w_re      = 1'b0;
        w_we      = 1'b0;
        w_waddr   = r_pidx;
        w_wdata   = w_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_req_pop = 1'b1;
                    n_req     = i_req;
                    n_found   = '0;
                    n_removed = '0;
                    n_rd      = '0;
                    n_w       = '0;
                    n_status  = ST_OK;
                    if (i_req.quick) begin
                        n_status = i_req.quick_status;
                        n_state  = S_DONE;
                    end else if (i_req.op == OP_INSERT) begin
                        if (w_limit == '0) begin
                            n_status = ST_MISS;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_INS;
                        end
                    end else if (i_req.op == OP_EXPIRE) begin
                        n_mode  = M_EXP;
                        n_state = S_SCAN;
                    end else begin
                        n_mode  = M_FIND;
                        n_state = S_SCAN;
                    end
                end
            end

            S_INS: begin
                if (r_total != '0 && (w_over || w_full)) begin
                    n_mode  = M_MIN;
                    n_rd    = '0;
                    n_state = S_SCAN;
                end else begin
                    w_we     = 1'b1;
                    w_waddr  = r_total[IW-1:0];
                    w_wdata  = {r_req.key_tag[TAG_BITS-1:0], r_req.handle, r_req.item_size,
                                r_req.now, 32'd1, r_req.local_flag};
                    n_total  = r_total + CW'(1);
                    n_bytes  = r_bytes + r_req.item_size;
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end
            end

            S_SCAN: begin
                if (r_rd < r_total) begin
                    w_re   = 1'b1;
                    n_rd   = r_rd + CW'(1);
                    n_pv   = 1'b1;
                    n_pidx = r_rd[IW-1:0];
                end
                if (r_pv) begin
                    unique case (r_mode)
                        M_FIND: begin
                            if (w_hit) begin
                                n_status = ST_OK;
                                n_pv     = 1'b0;
                                if (r_req.op == OP_LOOKUP) begin
                                    w_we    = 1'b1;
                                    w_wdata = {d_tag, d_hnd, d_siz, r_req.now, w_use_inc, d_loc};
                                    n_found = d_hnd;
                                    n_state = S_DONE;
                                end else if (r_req.op == OP_REMOVE) begin
                                    n_bytes = r_bytes - d_siz;
                                    n_mode  = M_SHIFT;
                                    n_rd    = CW'(r_pidx) + CW'(1);
                                end else begin
                                    n_state = S_DONE;
                                end
                            end
                        end
                        M_MIN: begin
                            if (r_pidx == '0 || w_less) begin
                                n_bu = d_use;
                                n_bt = d_tim;
                                n_bi = r_pidx;
                                n_bs = d_siz;
                            end
                        end
                        M_SHIFT: begin
                            w_we    = 1'b1;
                            w_waddr = r_pidx - IW'(1);
                        end
                        M_EXP: begin
                            if (w_expired) begin
                                n_bytes   = r_bytes - d_siz;
                                n_removed = r_removed + CW'(1);
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = r_w[IW-1:0];
                                n_w     = r_w + CW'(1);
                            end
                        end
                        default: ;
                    endcase
                end else if (w_end) begin
                    unique case (r_mode)
                        M_FIND: begin
                            n_status = ST_MISS;
                            n_state  = S_DONE;
                        end
                        M_MIN: begin
                            n_bytes = r_bytes - r_bs;
                            n_mode  = M_SHIFT;
                            n_rd    = CW'(r_bi) + CW'(1);
                        end
                        M_SHIFT: begin
                            n_total = r_total - CW'(1);
                            if (r_req.op == OP_REMOVE) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_INS;
                            end
                        end
                        M_EXP: begin
                            n_total  = r_w;
                            n_status = ST_OK;
                            n_state  = S_DONE;
                        end
                        default: ;
                    endcase
                end
            end

            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_rd      <= n_rd;
        r_pidx    <= n_pidx;
        r_w       <= n_w;
        r_removed <= n_removed;
        r_bu      <= n_bu;
        r_bt      <= n_bt;
        r_bi      <= n_bi;
        r_bs      <= n_bs;
        r_status  <= n_status;
        r_found   <= n_found;
        r_mode    <= n_mode;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_bytes <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_bytes <= n_bytes;
            r_pv    <= n_pv;
        end
    end

    lfu_ram #(
        .WIDTH(EW),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(r_rd[IW-1:0]),
        .o_rdata(w_rdata)
    );

endmodule

@@ design/lfu_size_budget_cache_table.sv @@
// A lookup, remove or presence check scans the table at one entry per cycle; an insert that
// must evict first scans for the victim and then shifts the later entries down; expiry scans
// and compacts the table in one pass.
// The back end runs one request at a time; the entry memory has one write and one read port.
// Reset (synchronous, active low) clears the entry and byte counts and both queues and loads
// the budget and limit defaults; the entry memory is not cleared.
module lfu_size_budget_cache_table
    import lfu_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEF,
    parameter int TAG_BITS    = TAG_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request side, a queue write port.
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_operation,
    input  logic [63:0] i_key_tag,
    input  logic [31:0] i_new_handle,
    input  logic [39:0] i_item_size,
    input  logic        i_local_flag,
    input  logic [31:0] i_now,
    input  logic [31:0] i_max_age,
    // Result side, a queue read port.
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [31:0] o_found_handle,
    output logic [10:0] o_removed_count,
    output logic [10:0] o_stored_entries,
    output logic [39:0] o_used_bytes,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    // The two registers sit at byte addresses 0 and 8, so address bit 3 selects one.
    logic [39:0] r_budget;
    logic [10:0] r_limit;
    logic        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= BUDGET_RST;
            r_limit  <= LIMIT_RST;
        end else if (w_cfg_wr) begin
            if (paddr[3] == REG_BUDGET) begin
                r_budget <= pwdata[39:0];
            end else begin
                r_limit <= pwdata[10:0];
            end
        end
    end

    assign prdata = (paddr[3] == REG_BUDGET) ? {24'd0, r_budget} : {53'd0, r_limit};

    // The front end takes each request, marks the ones that need no table
    // access, and holds up to two of them so the host is not held off while
    // the back end works through a long scan.
    t_req w_in_req;
    t_req w_head;
    logic w_head_valid;
    logic w_head_pop;

    always_comb begin
        w_in_req              = '0;
        w_in_req.op           = i_operation;
        w_in_req.key_tag      = i_key_tag;
        w_in_req.handle       = i_new_handle;
        w_in_req.item_size    = i_item_size;
        w_in_req.local_flag   = i_local_flag;
        w_in_req.now          = i_now;
        w_in_req.max_age      = i_max_age;
    end

    lfu_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_req  (w_in_req),
        .o_full (full),
        .o_valid(w_head_valid),
        .o_req  (w_head),
        .i_pop  (w_head_pop)
    );

    // The back end owns the entry memory and runs one request at a time.
    t_res w_res;
    logic w_res_valid;
    logic w_res_ready;

    lfu_back #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .TAG_BITS   (TAG_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(w_head_valid),
        .i_req      (w_head),
        .o_req_pop  (w_head_pop),
        .i_budget   (r_budget),
        .i_limit    (r_limit),
        .o_res_valid(w_res_valid),
        .o_res      (w_res),
        .i_res_ready(w_res_ready)
    );

    // Two-entry result queue: a finished result waits here while the back end
    // moves on to the next request.
    t_res       r_oq [2];
    logic       r_owp;
    logic       r_orp;
    logic [1:0] r_ocnt;
    logic       w_oq_push;
    logic       w_oq_pop;

    assign w_res_ready = !r_ocnt[1];
    assign w_oq_push   = w_res_valid && w_res_ready;
    assign empty       = r_ocnt == 2'd0;
    assign w_oq_pop    = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (w_oq_push) begin
            r_oq[r_owp] <= w_res;
        end
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (w_oq_push) begin
                r_owp <= !r_owp;
            end
            if (w_oq_pop) begin
                r_orp <= !r_orp;
            end
            r_ocnt <= r_ocnt + {1'b0, w_oq_push} - {1'b0, w_oq_pop};
        end
    end

    assign o_status         = r_oq[r_orp].status;
    assign o_found_handle   = r_oq[r_orp].found_handle;
    assign o_removed_count  = r_oq[r_orp].removed_count;
    assign o_stored_entries = r_oq[r_orp].stored_entries;
    assign o_used_bytes     = r_oq[r_orp].used_bytes;

endmodule

@@ tb/lfu_size_budget_cache_table_test.sv @@
module lfu_size_budget_cache_table_test;
    import lfu_pkg::*;

    // The table depth of the instance below; the predictor keeps a table of the same depth.
    localparam int DEPTH = 1024;
    // Operation code outside the defined set; the block must answer it with a miss.
    localparam logic [2:0] OP_UNUSED = 3'd7;
    // Register byte addresses; the budget is 40 bits wide, so registers sit 8 bytes apart.
    localparam logic [3:0] ADDR_BUDGET = 4'd0;
    localparam logic [3:0] ADDR_LIMIT  = 4'd8;
    // Cycles without any accepted request or result before the run is declared hung.
    // The slowest legal request is an insert that evicts a few hundred entries.
    localparam int HANG_LIMIT = 400000;

    typedef struct {
        logic [2:0]  op;
        logic [63:0] key;
        logic [31:0] handle;
        logic [39:0] size;
        logic        loc;
        logic [31:0] now;
        logic [31:0] max_age;
    } cache_req_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  i_operation = '0;
    logic [63:0] i_key_tag = '0;
    logic [31:0] i_new_handle = '0;
    logic [39:0] i_item_size = '0;
    logic        i_local_flag = 1'b0;
    logic [31:0] i_now = '0;
    logic [31:0] i_max_age = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_found_handle;
    logic [10:0] o_removed_count;
    logic [10:0] o_stored_entries;
    logic [39:0] o_used_bytes;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    lfu_size_budget_cache_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full),
        .i_operation(i_operation), .i_key_tag(i_key_tag), .i_new_handle(i_new_handle),
        .i_item_size(i_item_size), .i_local_flag(i_local_flag), .i_now(i_now),
        .i_max_age(i_max_age),
        .empty(empty), .pop(pop),
        .o_status(o_status), .o_found_handle(o_found_handle),
        .o_removed_count(o_removed_count), .o_stored_entries(o_stored_entries),
        .o_used_bytes(o_used_bytes),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: a copy of the cache table and its configuration.
    // ------------------------------------------------------------------
    logic [63:0] tbl_tag    [DEPTH];
    logic [31:0] tbl_handle [DEPTH];
    logic [39:0] tbl_size   [DEPTH];
    logic [31:0] tbl_time   [DEPTH];
    logic [31:0] tbl_uses   [DEPTH];
    logic        tbl_local  [DEPTH];
    int          tbl_count = 0;
    logic [39:0] tbl_bytes = '0;
    logic [39:0] cfg_budget = BUDGET_RST;
    logic [10:0] cfg_limit = LIMIT_RST;

    t_res pending_results[$];
    int   err_count = 0;
    bit   no_idle = 0;
    int   pop_wait = 0;
    int   hang_count = 0;

    // Keys are drawn mostly from a small pool so that lookups and removes hit.
    logic [63:0] key_pool[24];
    logic [31:0] clock_secs = 32'd1000;

    function automatic int find_key(logic [63:0] key);
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_tag[i] == key) return i;
        end
        return -1;
    endfunction

    function automatic void copy_entry(int dst, int src);
        tbl_tag[dst]    = tbl_tag[src];
        tbl_handle[dst] = tbl_handle[src];
        tbl_size[dst]   = tbl_size[src];
        tbl_time[dst]   = tbl_time[src];
        tbl_uses[dst]   = tbl_uses[src];
        tbl_local[dst]  = tbl_local[src];
    endfunction

    // Removal keeps the remaining entries in order.
    function automatic void drop_entry(int idx);
        tbl_bytes = tbl_bytes - tbl_size[idx];
        for (int i = idx; i + 1 < tbl_count; i++) copy_entry(i, i + 1);
        tbl_count--;
    endfunction

    // Fewest uses first, then the oldest stamp, then the lowest index.
    function automatic int pick_victim();
        int best = 0;
        for (int i = 1; i < tbl_count; i++) begin
            if (tbl_uses[i] < tbl_uses[best] ||
                (tbl_uses[i] == tbl_uses[best] && tbl_time[i] < tbl_time[best]))
                best = i;
        end
        return best;
    endfunction

    function automatic t_res predict_cache_result(cache_req_t r);
        t_res        res;
        int          idx;
        int          keep;
        int          limit;
        logic [40:0] need;
        longint      age;
        res = '0;
        res.status = ST_MISS;
        limit = (cfg_limit > DEPTH) ? DEPTH : int'(cfg_limit);
        case (r.op)
            OP_LOOKUP: begin
                idx = find_key(r.key);
                if (idx >= 0) begin
                    if (tbl_uses[idx] != 32'hFFFF_FFFF) tbl_uses[idx]++;
                    tbl_time[idx] = r.now;
                    res.found_handle = tbl_handle[idx];
                    res.status = ST_OK;
                end
            end
            OP_INSERT: begin
                if (r.size == 0) begin
                    res.status = ST_ZERO;
                end else if (limit != 0) begin
                    forever begin
                        need = {1'b0, tbl_bytes} + {1'b0, r.size};
                        if (tbl_count == 0 ||
                            !(need > {1'b0, cfg_budget} || tbl_count >= limit)) break;
                        drop_entry(pick_victim());
                    end
                    if (tbl_count < limit) begin
                        tbl_tag[tbl_count]    = r.key;
                        tbl_handle[tbl_count] = r.handle;
                        tbl_size[tbl_count]   = r.size;
                        tbl_time[tbl_count]   = r.now;
                        tbl_uses[tbl_count]   = 32'd1;
                        tbl_local[tbl_count]  = r.loc;
                        tbl_count++;
                        tbl_bytes = tbl_bytes + r.size;
                        res.status = ST_OK;
                    end
                end
            end
            OP_REMOVE: begin
                idx = find_key(r.key);
                if (idx >= 0) begin
                    drop_entry(idx);
                    res.status = ST_OK;
                end
            end
            OP_PRESENCE: begin
                res.status = (find_key(r.key) >= 0) ? ST_OK : ST_MISS;
            end
            OP_EXPIRE: begin
                // The age is a signed difference, so stamps in the future never expire.
                keep = 0;
                for (int i = 0; i < tbl_count; i++) begin
                    age = longint'({32'b0, r.now}) - longint'({32'b0, tbl_time[i]});
                    if (age > longint'({32'b0, r.max_age})) begin
                        tbl_bytes = tbl_bytes - tbl_size[i];
                        res.removed_count++;
                    end else begin
                        if (keep != i) copy_entry(keep, i);
                        keep++;
                    end
                end
                tbl_count = keep;
                res.status = ST_OK;
            end
            default: ;
        endcase
        res.stored_entries = tbl_count[10:0];
        res.used_bytes = tbl_bytes;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request side. push stays high across back-to-back requests, so it is
    // lowered only when a gap is drawn, and never in the same time step
    // in which it is raised again.
    // ------------------------------------------------------------------
    task automatic send_request(cache_req_t r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_operation  <= r.op;
        i_key_tag    <= r.key;
        i_new_handle <= r.handle;
        i_item_size  <= r.size;
        i_local_flag <= r.loc;
        i_now        <= r.now;
        i_max_age    <= r.max_age;
        do @(posedge i_clk); while (full);
        pending_results.push_back(predict_cache_result(r));
    endtask

    // Waits until every predicted result has been popped, then lets the
    // block settle before a register write.
    task automatic wait_drained();
        push <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Two-phase write; pready is always high, so the access phase never waits.
    task automatic write_register(logic [3:0] addr, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_BUDGET) cfg_budget = value[39:0];
        else cfg_limit = value[10:0];
    endtask

    task automatic set_config(logic [39:0] budget, logic [10:0] limit);
        wait_drained();
        write_register(ADDR_BUDGET, {24'b0, budget});
        write_register(ADDR_LIMIT, {53'b0, limit});
    endtask

    function automatic cache_req_t make_req(logic [2:0] op, logic [63:0] key,
                                            logic [39:0] size, logic [31:0] now,
                                            logic [31:0] max_age);
        cache_req_t r;
        r.op = op;
        r.key = key;
        r.handle = $urandom;
        r.size = size;
        r.loc = 1'($urandom_range(0, 1));
        r.now = now;
        r.max_age = max_age;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: checks each popped result against the oldest prediction,
    // draws a stall for the next one and watches for a hang.
    // ------------------------------------------------------------------
    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch on %s: got %0h, expected %0h", field, got, want);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if ((push && !full) || (pop && !empty)) hang_count = 0;
        else hang_count++;
        if (hang_count >= HANG_LIMIT) begin
            $display("lfu_size_budget_cache_table_test: errors");
            $finish;
        end else begin
            if (pop && !empty) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", 64'd1, 64'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", 64'(o_status), 64'(want.status));
                    if (o_found_handle !== want.found_handle)
                        report_mismatch("found_handle", 64'(o_found_handle),
                                        64'(want.found_handle));
                    if (o_removed_count !== want.removed_count)
                        report_mismatch("removed_count", 64'(o_removed_count),
                                        64'(want.removed_count));
                    if (o_stored_entries !== want.stored_entries)
                        report_mismatch("stored_entries", 64'(o_stored_entries),
                                        64'(want.stored_entries));
                    if (o_used_bytes !== want.used_bytes)
                        report_mismatch("used_bytes", 64'(o_used_bytes),
                                        64'(want.used_bytes));
                end
                pop_wait = no_idle ? 0 : $urandom_range(0, 12);
            end
            if (!i_rst_n || pop_wait > 0) begin
                if (pop_wait > 0) pop_wait--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Basic operations at the reset configuration: a rejected zero size,
    // hits and misses, duplicate keys, an item over the budget, a stamp in
    // the future and an unknown operation.
    task automatic test_basic_operations();
        logic [63:0] ka;
        logic [63:0] kb;
        ka = key_pool[0];
        kb = key_pool[1];
        send_request(make_req(OP_INSERT, ka, 40'd0, 32'd10, 32'd0));
        send_request(make_req(OP_INSERT, ka, 40'd100, 32'd10, 32'd0));
        send_request(make_req(OP_INSERT, ka, 40'd200, 32'd11, 32'd0));
        send_request(make_req(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 40'd1, 32'd12, 32'd0));
        send_request(make_req(OP_INSERT, 64'd0, 40'd7, 32'hFFFF_FFFF, 32'd0));
        send_request(make_req(OP_LOOKUP, ka, 40'd0, 32'd13, 32'd0));
        send_request(make_req(OP_LOOKUP, kb, 40'd0, 32'd13, 32'd0));
        send_request(make_req(OP_PRESENCE, 64'hFFFF_FFFF_FFFF_FFFF, 40'd0, 32'd14, 32'd0));
        send_request(make_req(OP_PRESENCE, kb, 40'd0, 32'd14, 32'd0));
        send_request(make_req(OP_REMOVE, ka, 40'd0, 32'd15, 32'd0));
        send_request(make_req(OP_LOOKUP, ka, 40'd0, 32'd16, 32'd0));
        send_request(make_req(OP_REMOVE, kb, 40'd0, 32'd16, 32'd0));
        send_request(make_req(OP_UNUSED, ka, 40'd5, 32'd17, 32'd0));
        send_request(make_req(3'd5, ka, 40'd5, 32'd17, 32'd0));
        send_request(make_req(OP_EXPIRE, ka, 40'd0, 32'd20, 32'd5));
        send_request(make_req(OP_EXPIRE, ka, 40'd0, 32'hFFFF_FFFF, 32'd0));
        // An item larger than the whole budget empties the table and is still stored.
        send_request(make_req(OP_INSERT, kb, 40'd9, 32'd30, 32'd0));
        send_request(make_req(OP_INSERT, ka, 40'hFF_FFFF_FFFF, 32'd31, 32'd0));
        send_request(make_req(OP_EXPIRE, ka, 40'd0, 32'd0, 32'hFFFF_FFFF));
    endtask

    // The entry limit at zero, one and above the table depth, and the budget extremes.
    task automatic test_limits();
        set_config(40'd1000, 11'd0);
        send_request(make_req(OP_INSERT, key_pool[2], 40'd10, 32'd40, 32'd0));
        set_config(40'd1, 11'd1);
        send_request(make_req(OP_INSERT, key_pool[3], 40'd1, 32'd41, 32'd0));
        send_request(make_req(OP_INSERT, key_pool[4], 40'd1, 32'd42, 32'd0));
        send_request(make_req(OP_INSERT, key_pool[5], 40'd3, 32'd43, 32'd0));
        set_config(40'hFF_FFFF_FFFF, 11'd2047);
        send_request(make_req(OP_INSERT, key_pool[6], 40'hFF_FFFF_FFFF, 32'd44, 32'd0));
        send_request(make_req(OP_INSERT, key_pool[7], 40'd1, 32'd45, 32'd0));
        send_request(make_req(OP_EXPIRE, key_pool[7], 40'd0, 32'd100, 32'd10));
    endtask

    function automatic cache_req_t random_req();
        cache_req_t r;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) r.op = OP_INSERT;
        else if (pick < 60) r.op = OP_LOOKUP;
        else if (pick < 72) r.op = OP_REMOVE;
        else if (pick < 86) r.op = OP_PRESENCE;
        else if (pick < 95) r.op = OP_EXPIRE;
        else r.op = 3'($urandom_range(5, 7));
        r.key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                            : key_pool[$urandom_range(0, 23)];
        r.handle = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 5) r.size = '0;
        else if (pick < 10 && tbl_count < 16) r.size = 40'({$urandom, $urandom});
        else r.size = 40'($urandom_range(1, 4000));
        r.loc = 1'($urandom_range(0, 1));
        clock_secs = clock_secs + $urandom_range(0, 20);
        r.now = ($urandom_range(0, 19) == 0) ? 32'($urandom) : clock_secs;
        pick = $urandom_range(0, 19);
        if (pick == 0) r.max_age = 32'($urandom);
        else if (pick == 1) r.max_age = 32'hFFFF_FFFF;
        else if (pick == 2) r.max_age = '0;
        else r.max_age = 32'($urandom_range(20, 400));
        return r;
    endfunction

    // Random traffic under several configurations; one phase runs with no
    // idling on either side, and one pauses mid-phase until everything drains.
    task automatic test_random_traffic();
        logic [39:0] budgets[5] = '{40'd20000, 40'hFF_FFFF_FFFF, 40'd5000, 40'd1, 40'd60000};
        logic [10:0] limits[5]  = '{11'd16, 11'd1024, 11'd2047, 11'd8, 11'd64};
        for (int p = 0; p < 5; p++) begin
            set_config(budgets[p], limits[p]);
            no_idle = (p == 2);
            for (int n = 0; n < 86; n++) begin
                if (p == 1 && n == 40) wait_drained();
                send_request(random_req());
            end
        end
        no_idle = 0;
    endtask

    initial begin
        for (int i = 0; i < 24; i++) key_pool[i] = {$urandom, $urandom};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_operations();
        test_limits();
        test_random_traffic();
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("lfu_size_budget_cache_table_test: clean");
        end else begin
            $display("lfu_size_budget_cache_table_test: errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/lfu_pkg.sv
design/lfu_ram.sv
design/lfu_front.sv
design/lfu_back.sv
design/lfu_size_budget_cache_table.sv
tb/lfu_size_budget_cache_table_test.sv
